// ===== design/hrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_pkg: shared types and constants for the HRF convolution filter
// Field widths, item mode codes, sequencer states and the MAC control word.
// ----------------------------------------------------------------------------
package hrf_pkg;

  // Fixed widths of the interface fields
  localparam int FIELD_W     = 16;
  localparam int IDX_FIELD_W = 9;
  localparam int OUT_W       = 40;

  // Item mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } hrf_state_t;

  // Control word for the MAC, aligned with the memory read data
  typedef struct packed {
    logic clr;      // clear accumulator for a new sample
    logic en;       // read data valid this cycle
    logic last;     // final tap of this sample
    logic hist_ok;  // history entry has been written since reset
  } hrf_mac_ctl_t;

endpackage
`default_nettype wire

// ===== design/hrf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_ram: simple dual-port synchronous memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 300
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/hrf_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_mac: shared multiply-accumulate unit
// Registered product, then a wrapping 40-bit accumulate; pulses done after
// the last tap has been added.
// ----------------------------------------------------------------------------
module hrf_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hrf_pkg::hrf_mac_ctl_t             ctl,
  input  wire logic signed [COEF_BITS-1:0]       coef,
  input  wire logic signed [SAMPLE_BITS-1:0]     smp,
  output logic signed [hrf_pkg::OUT_W-1:0]       acc,
  output logic                                   done
);

  localparam int PW = SAMPLE_BITS + COEF_BITS;
  localparam int OW = hrf_pkg::OUT_W;

  logic signed [SAMPLE_BITS-1:0] smp_m;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [PW-1:0]          prod_r;
  logic                          pv_r;
  logic                          plast_r;
  logic signed [OW-1:0]          acc_r;
  logic                          done_r;

  // unwritten history slots count as zero
  assign smp_m    = ctl.hist_ok ? smp : '0;
  assign prod_nxt = PW'(coef) * PW'(smp_m);

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      plast_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      pv_r    <= ctl.en;
      plast_r <= ctl.en & ctl.last;
      done_r  <= pv_r & plast_r;
    end
  end

  // accumulate stage, wraps modulo 2^40
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + OW'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== design/hrf_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_seq: sample sequencer
// Walks the tap and history memories for one sample, tracks the delay-line
// write pointer and fill count, and retires the result.
// ----------------------------------------------------------------------------
module hrf_seq #(
  parameter int TAPS = 300
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  input  wire logic                                     in_mode,
  input  wire logic [hrf_pkg::IDX_FIELD_W-1:0]          in_tap_index,
  input  wire logic                                     acc_done,
  input  wire logic                                     out_busy,
  output logic                                          in_ready,
  output logic                                          tap_we,
  output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0]      tap_waddr,
  output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0]      tap_raddr,
  output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0]      hist_raddr,
  output logic                                          hist_we,
  output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0]      hist_waddr,
  output hrf_pkg::hrf_mac_ctl_t                         mac_ctl,
  output logic                                          out_load
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW = $clog2(TAPS + 1);
  localparam int CW = (FW > IW) ? FW : IW;
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);
  localparam logic [FW-1:0] FULL = FW'(TAPS);

  hrf_pkg::hrf_state_t   state_r, state_nxt;
  logic [IW-1:0]         k_r, k_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  logic [IW-1:0]         wp_r, wp_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  hrf_pkg::hrf_mac_ctl_t mac_ctl_r, mac_ctl_nxt;
  logic                  accept;
  logic                  is_sample;
  logic                  issue;

  assign in_ready  = (state_r == hrf_pkg::ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign is_sample = (in_mode == hrf_pkg::MODE_SAMPLE);
  assign issue     = (state_r == hrf_pkg::ST_RUN);

  // tap loads go straight to the coefficient memory; out-of-range dropped
  assign tap_we    = accept & ~is_sample & (32'(in_tap_index) < TAPS);
  assign tap_waddr = IW'(in_tap_index);
  assign tap_raddr = k_r;
  assign hist_raddr = slot_r;
  assign hist_waddr = wp_r;
  assign mac_ctl    = mac_ctl_r;

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    slot_nxt  = slot_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    hist_we   = 1'b0;
    out_load  = 1'b0;

    mac_ctl_nxt.clr     = accept & is_sample;
    mac_ctl_nxt.en      = issue;
    mac_ctl_nxt.last    = issue & (k_r == LAST);
    mac_ctl_nxt.hist_ok = (CW'(slot_r) < CW'(fill_r));

    unique case (state_r)
      hrf_pkg::ST_IDLE: begin
        if (accept && is_sample) begin
          state_nxt = hrf_pkg::ST_RUN;
          k_nxt     = '0;
          slot_nxt  = (wp_r == '0) ? LAST : wp_r - IW'(1);
        end
      end
      hrf_pkg::ST_RUN: begin
        k_nxt    = k_r + IW'(1);
        slot_nxt = (slot_r == '0) ? LAST : slot_r - IW'(1);
        if (k_r == LAST) begin
          state_nxt = hrf_pkg::ST_DRAIN;
        end
      end
      hrf_pkg::ST_DRAIN: begin
        if (acc_done) begin
          state_nxt = hrf_pkg::ST_FIN;
        end
      end
      hrf_pkg::ST_FIN: begin
        // retire once the output register is free
        if (!out_busy) begin
          hist_we   = 1'b1;
          out_load  = 1'b1;
          wp_nxt    = (wp_r == LAST) ? '0 : wp_r + IW'(1);
          fill_nxt  = (fill_r == FULL) ? fill_r : fill_r + FW'(1);
          state_nxt = hrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hrf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hrf_pkg::ST_IDLE;
      wp_r      <= '0;
      fill_r    <= '0;
      mac_ctl_r <= '0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      mac_ctl_r <= mac_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    slot_r <= slot_nxt;
  end

`ifndef SYNTHESIS
  // history write never overlaps a read in flight
  a_no_hist_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> !mac_ctl_r.en && !issue)
    else $error("history write during tap walk");

  // the walk ends after the last tap
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && k_r == LAST) |=> (state_r == hrf_pkg::ST_DRAIN))
    else $error("tap walk did not end on last tap");

  // fill count saturates at the delay-line length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(FULL))
    else $error("fill count beyond depth");

  // write pointer advances by one slot per retired sample
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> (wp_r == (($past(wp_r) == LAST) ? '0 : $past(wp_r) + IW'(1))))
    else $error("write pointer step wrong");
`endif

endmodule
`default_nettype wire

// ===== design/hrf_convolution_fir.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_convolution_fir: causal FIR convolution with a hemodynamic kernel
// Load words write one Q2.14 tap; sample words return the sum of taps times
// earlier samples, then push the sample into the delay line.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_mode, in_tap_index, in_tap_value, in_sample
//  out      out_valid / out_ready  out_filtered
//
//  A load word leaves the sequencer idle and ready for the next word. A
//  sample word walks all TAPS taps through one shared MAC, one tap per cycle
//  from the tap and history memories; the next word is taken on the cycle
//  after the result is registered.
//  History reads as zero until written (fill count); no clearing pass.
//  Reset is synchronous, active low. A result waiting in the output register
//  does not block new words; a second result stalls the sequencer in its
//  final state, and no word is taken until that result is registered.
//
module hrf_convolution_fir #(
  parameter int TAPS        = 300,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_mode,
  input  wire logic        [hrf_pkg::IDX_FIELD_W-1:0] in_tap_index,
  input  wire logic signed [hrf_pkg::FIELD_W-1:0]     in_tap_value,
  input  wire logic signed [hrf_pkg::FIELD_W-1:0]     in_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [hrf_pkg::OUT_W-1:0]       out_filtered
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;

  logic                          tap_we;
  logic [IW-1:0]                 tap_waddr;
  logic [IW-1:0]                 tap_raddr;
  logic [IW-1:0]                 hist_raddr;
  logic                          hist_we;
  logic [IW-1:0]                 hist_waddr;
  hrf_pkg::hrf_mac_ctl_t         mac_ctl;
  logic                          out_load;
  logic                          acc_done;
  logic                          out_busy;
  logic signed [COEF_BITS-1:0]   tap_wdata;
  logic signed [COEF_BITS-1:0]   tap_rdata;
  logic signed [SAMPLE_BITS-1:0] hist_rdata;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [hrf_pkg::OUT_W-1:0] acc;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [hrf_pkg::OUT_W-1:0] out_filtered_r;

  // field values wrapped or extended to storage width
  assign tap_wdata = COEF_BITS'(in_tap_value);

  // sequencer
  hrf_seq #(
    .TAPS (TAPS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_tap_index (in_tap_index),
    .acc_done     (acc_done),
    .out_busy     (out_busy),
    .in_ready     (in_ready),
    .tap_we       (tap_we),
    .tap_waddr    (tap_waddr),
    .tap_raddr    (tap_raddr),
    .hist_raddr   (hist_raddr),
    .hist_we      (hist_we),
    .hist_waddr   (hist_waddr),
    .mac_ctl      (mac_ctl),
    .out_load     (out_load)
  );

  // coefficient store
  hrf_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  // delay line
  hrf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (sample_r),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // shared MAC
  hrf_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (tap_rdata),
    .smp   (hist_rdata),
    .acc   (acc),
    .done  (acc_done)
  );

  // hold the incoming sample until it is pushed into the delay line
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_mode == hrf_pkg::MODE_SAMPLE) begin
      sample_r <= SAMPLE_BITS'(in_sample);
    end
  end

  // output register
  assign out_busy = out_valid_r & ~out_ready;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= acc;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule
`default_nettype wire

// ===== tb/sv/hrf_convolution_fir_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrf_convolution_fir_test: self-checking bench for the HRF convolution FIR
// Fills the kernel, walks a table of directed words, drives the widest sums on both
// extreme kernels, then sends random load and sample words. Every accepted sample word
// gets a predicted sum that the returned word is compared against, oldest first.
// ----------------------------------------------------------------------------
module hrf_convolution_fir_test;

  localparam int TAPS        = 300;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int TOTAL_WORDS = 1750;
  localparam int DIR_ROWS    = 18;
  localparam int CYCLE_LIMIT = 3_000_000;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    logic                                mode;
    logic [hrf_pkg::IDX_FIELD_W-1:0]     idx;
    logic signed [hrf_pkg::FIELD_W-1:0]  tval;
    logic signed [hrf_pkg::FIELD_W-1:0]  samp;
    bit                                  typed;
    logic signed [hrf_pkg::OUT_W-1:0]    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  logic [hrf_pkg::IDX_FIELD_W-1:0] in_tap_index;
  logic signed [hrf_pkg::FIELD_W-1:0] in_tap_value;
  logic signed [hrf_pkg::FIELD_W-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic signed [hrf_pkg::OUT_W-1:0] out_filtered;

  // predictor state
  logic signed [hrf_pkg::FIELD_W-1:0] hist_line [TAPS];
  logic signed [hrf_pkg::FIELD_W-1:0] coef [TAPS];
  int unsigned                        wr_slot;

  // sums waiting for their word on the out channel
  logic signed [hrf_pkg::OUT_W-1:0] filtered_due [$];

  // side info for the word currently on the in channel
  bit                               row_typed;
  logic signed [hrf_pkg::OUT_W-1:0] row_want;

  bit       steady;
  int       mismatches;
  dir_row_t plan [DIR_ROWS];

  hrf_convolution_fir #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // about 27 idle cycles in a hundred, none in the steady window
  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 27);
  endfunction

  // sum of taps times earlier samples, newest sample against tap 0
  function automatic logic signed [hrf_pkg::OUT_W-1:0] fir_sum();
    longint acc;
    int     k;
    int     slot;
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      slot = (wr_slot + TAPS - 1 - k) % TAPS;
      acc += longint'(coef[k]) * longint'(hist_line[slot]);
    end
    return acc[hrf_pkg::OUT_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what,
                               input logic signed [hrf_pkg::OUT_W-1:0] want,
                               input logic signed [hrf_pkg::OUT_W-1:0] got);
    $display("mismatch at %0t: %s want %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // drive one word from a falling edge, hold until taken, end on a falling edge
  task automatic push_word(input logic mode,
                           input logic [hrf_pkg::IDX_FIELD_W-1:0] idx,
                           input logic signed [hrf_pkg::FIELD_W-1:0] tval,
                           input logic signed [hrf_pkg::FIELD_W-1:0] samp,
                           input bit typed,
                           input logic signed [hrf_pkg::OUT_W-1:0] want);
    if (take_break()) begin
      in_valid = 1'b0;
      @(negedge clk);
      while (take_break()) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_mode      = mode;
    in_tap_index = idx;
    in_tap_value = tval;
    in_sample    = samp;
    row_typed    = typed;
    row_want     = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_load(input logic [hrf_pkg::IDX_FIELD_W-1:0] idx,
                           input logic signed [hrf_pkg::FIELD_W-1:0] tval);
    push_word(hrf_pkg::MODE_LOAD, idx, tval, hrf_pkg::FIELD_W'($urandom), 1'b0, '0);
  endtask

  task automatic push_sample(input logic signed [hrf_pkg::FIELD_W-1:0] samp);
    push_word(hrf_pkg::MODE_SAMPLE, hrf_pkg::IDX_FIELD_W'($urandom),
              hrf_pkg::FIELD_W'($urandom), samp, 1'b0, '0);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready = !take_break();
  end

  // monitor: check returned sums, track accepted words in the predictor
  always @(posedge clk) begin : watch
    logic signed [hrf_pkg::OUT_W-1:0] due;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (filtered_due.size() == 0) begin
          flag_mismatch("result word with nothing due", '0, out_filtered);
        end else begin
          due = filtered_due.pop_front();
          if (out_filtered !== due) flag_mismatch("filtered", due, out_filtered);
        end
      end
      if (in_valid && in_ready) begin
        if (in_mode == hrf_pkg::MODE_SAMPLE) begin
          due = fir_sum();
          filtered_due.push_back(row_typed ? row_want : due);
          hist_line[wr_slot] = in_sample;
          wr_slot = (wr_slot + 1) % TAPS;
        end else if (in_tap_index < TAPS) begin
          coef[in_tap_index] = in_tap_value;
        end
      end
    end
  end

  // run-away guard
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("hrf_convolution_fir_test NOT OK");
    $finish;
  end

  initial begin : stim
    int i;
    int sent;
    int pick;
    logic [hrf_pkg::IDX_FIELD_W-1:0] idx;
    logic signed [hrf_pkg::FIELD_W-1:0] samp;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = hrf_pkg::MODE_LOAD;
    in_tap_index = '0;
    in_tap_value = '0;
    in_sample    = '0;
    out_ready    = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    steady       = 1'b0;
    mismatches   = 0;
    wr_slot      = 0;
    for (i = 0; i < TAPS; i++) begin
      hist_line[i] = '0;
      coef[i]      = '0;
    end

    // directed rows; typed sums follow from a zero kernel and empty history
    plan = '{
      '{hrf_pkg::MODE_LOAD,   9'd0,   16'sh8000, 16'sh7fff, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_LOAD,   9'd300, 16'sh1234, 16'sh0000, 1'b0, 40'sd0},  // past the end
      '{hrf_pkg::MODE_LOAD,   9'h1ff, 16'sh7fff, 16'sh8000, 1'b0, 40'sd0},  // past the end
      '{hrf_pkg::MODE_SAMPLE, 9'h1ff, 16'shffff, 16'sh8000, 1'b1, 40'sd0},  // empty history
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'sh7fff, 1'b1, 40'sd1073741824},
      '{hrf_pkg::MODE_LOAD,   9'd299, 16'sh7fff, 16'sh0000, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'd299, 16'shffff, 16'sh0000, 1'b1, -40'sd1073709056},
      '{hrf_pkg::MODE_LOAD,   9'd1,   16'sh7fff, 16'sh0000, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'sh0001, 1'b1, 40'sd1073676289},
      '{hrf_pkg::MODE_LOAD,   9'd2,   16'shffff, 16'sh0000, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'shffff, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_LOAD,   9'd150, 16'sh4000, 16'sh0000, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'sh0001, 1'b0, 40'sd0},  // boxcar on
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'sh0001, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'd0,   16'sh0000, 16'sh0000, 1'b0, 40'sd0},  // boxcar off
      '{hrf_pkg::MODE_LOAD,   9'd0,   16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'h0aa, 16'sh5555, 16'sh5555, 1'b0, 40'sd0},
      '{hrf_pkg::MODE_SAMPLE, 9'h155, 16'shaaaa, 16'shaaaa, 1'b0, 40'sd0}
    };

    // synchronous reset, released on a falling edge
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // every tap is written before the first sample reads the kernel
    for (i = 0; i < TAPS; i++) push_load(hrf_pkg::IDX_FIELD_W'(i), 16'sh0000);

    for (i = 0; i < DIR_ROWS; i++)
      push_word(plan[i].mode, plan[i].idx, plan[i].tval, plan[i].samp,
                plan[i].typed, plan[i].want);

    // widest sums: full history of minimum samples against both extreme kernels
    sent = 0;
    for (i = 0; i < TAPS; i++) push_load(hrf_pkg::IDX_FIELD_W'(i), 16'sh8000);
    for (i = 0; i <= TAPS; i++) push_sample(16'sh8000);
    for (i = 0; i < TAPS; i++) push_load(hrf_pkg::IDX_FIELD_W'(i), 16'sh7fff);
    push_sample(16'sh7fff);
    sent = TAPS + DIR_ROWS + 3 * TAPS + 2;

    // random mix of loads and samples
    while (sent < TOTAL_WORDS) begin
      steady = (sent >= 1300) && (sent < 1550);
      pick = $urandom_range(0, 99);
      if (pick < 27) begin
        if ($urandom_range(0, 9) == 0)
          idx = hrf_pkg::IDX_FIELD_W'($urandom_range(TAPS, 511));
        else
          idx = hrf_pkg::IDX_FIELD_W'($urandom_range(0, TAPS - 1));
        push_load(idx, hrf_pkg::FIELD_W'($urandom));
      end else begin
        if ($urandom_range(0, 4) == 0) samp = hrf_pkg::FIELD_W'($urandom_range(0, 1));
        else samp = hrf_pkg::FIELD_W'($urandom);
        push_sample(samp);
      end
      sent++;
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // drain, then a quiet stretch to catch stray words
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (TAPS + 20) @(posedge clk);

    if (mismatches == 0) begin
      $display("hrf_convolution_fir_test OK");
    end else begin
      $display("hrf_convolution_fir_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== hrf_convolution_fir.f =====
design/hrf_pkg.sv
design/hrf_ram.sv
design/hrf_mac.sv
design/hrf_seq.sv
design/hrf_convolution_fir.sv
tb/sv/hrf_convolution_fir_test.sv
